@@ rtl/core/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, character codes and saturating depth helpers for the
// expression simplicity checker.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int DEPTH_WIDTH = 8;

    typedef logic signed [DEPTH_WIDTH-1:0] t_depth;

    localparam t_depth DEPTH_MAX  = t_depth'((1 << (DEPTH_WIDTH - 1)) - 1);
    localparam t_depth DEPTH_MIN  = t_depth'(1 << (DEPTH_WIDTH - 1));
    localparam t_depth DEPTH_ZERO = t_depth'(0);

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;

    // Token classes produced by the front end
    typedef logic [3:0] t_cls;
    localparam t_cls CLS_OTHER  = 4'd0;
    localparam t_cls CLS_BLANK  = 4'd1;
    localparam t_cls CLS_DQUOTE = 4'd2;
    localparam t_cls CLS_LPAREN = 4'd3;
    localparam t_cls CLS_RPAREN = 4'd4;
    localparam t_cls CLS_LSQ    = 4'd5;
    localparam t_cls CLS_RSQ    = 4'd6;
    localparam t_cls CLS_LT     = 4'd7;
    localparam t_cls CLS_GT     = 4'd8;
    localparam t_cls CLS_LBRACE = 4'd9;
    localparam t_cls CLS_RBRACE = 4'd10;
    localparam t_cls CLS_OP     = 4'd11;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_token;

    // Pending angle codes
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_LT   = 2'd1;
    localparam logic [1:0] PEND_GT   = 2'd2;

    // Verdict codes
    localparam logic [2:0] V_COMPLEX = 3'd0;
    localparam logic [2:0] V_SIMPLE  = 3'd1;
    localparam logic [2:0] V_QUOTE   = 3'd2;
    localparam logic [2:0] V_PAREN   = 3'd3;
    localparam logic [2:0] V_SQUARE  = 3'd4;
    localparam logic [2:0] V_LIST    = 3'd5;
    localparam logic [2:0] V_BRACE   = 3'd6;

    function automatic t_depth sat_inc(input t_depth v);
        return (v == DEPTH_MAX) ? v : t_depth'(v + t_depth'(1));
    endfunction

    function automatic t_depth sat_dec(input t_depth v);
        return (v == DEPTH_MIN) ? v : t_depth'(v - t_depth'(1));
    endfunction

endpackage

@@ rtl/core/expression_simplicity_checker.sv @@
// ----------------------------------------------------------------------------
// expression_simplicity_checker
// Scans an expression one character per transaction and reports whether it
// is simple, complex, or which delimiter was left unmatched.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------
//  input   | i_valid / o_ready  | i_char_code[7:0], i_last_char
//  output  | o_valid / i_ready  | o_verdict[2:0]
//
//  One character per cycle sustained while the output is not stalled; the
//  front end classifies in the accept cycle and the back end updates its
//  counters one token per cycle. The verdict register loads when the last
//  character's token leaves the queue, and o_valid rises with it.
//  Synchronous active-low reset clears the queue and all scan state.
//  A stalled output blocks only a final token; the two-entry queue then
//  takes one more character before o_ready drops.
// ----------------------------------------------------------------------------
module expression_simplicity_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_verdict
);
    import esc_pkg::*;

    t_token front_token;
    t_token queue_token;
    logic   queue_full;
    logic   queue_valid;
    logic   queue_pop;
    logic   accept;

    assign o_ready = !queue_full;
    assign accept  = i_valid && !queue_full;

    esc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_accept    (accept),
        .o_token     (front_token)
    );

    esc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_token (front_token),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_token (queue_token)
    );

    esc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (queue_valid),
        .i_token   (queue_token),
        .o_pop     (queue_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_verdict (o_verdict)
    );

endmodule

@@ rtl/core/esc_front.sv @@
// ----------------------------------------------------------------------------
// esc_front
// Accepts characters, tracks the backslash run parity and maps each byte
// to a token class for the back end.
// ----------------------------------------------------------------------------
module esc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_char_code,
    input  logic            i_last_char,
    input  logic            i_accept,
    output esc_pkg::t_token o_token
);
    import esc_pkg::*;

    logic r_bs_odd;
    logic n_bs_odd;
    t_cls cls;

    always_comb begin
        unique case (i_char_code)
            CH_SPACE, CH_TAB: cls = CLS_BLANK;
            CH_DQUOTE:        cls = r_bs_odd ? CLS_OTHER : CLS_DQUOTE;
            CH_LPAREN:        cls = CLS_LPAREN;
            CH_RPAREN:        cls = CLS_RPAREN;
            CH_LSQ:           cls = CLS_LSQ;
            CH_RSQ:           cls = CLS_RSQ;
            CH_LT:            cls = CLS_LT;
            CH_GT:            cls = CLS_GT;
            CH_LBRACE:        cls = CLS_LBRACE;
            CH_RBRACE:        cls = CLS_RBRACE;
            CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_CARET, CH_BANG,
            CH_PCT, CH_PIPE, CH_AMP, CH_EQ, CH_SQUOTE:
                              cls = CLS_OP;
            default:          cls = CLS_OTHER;
        endcase
    end

    assign o_token.cls  = cls;
    assign o_token.last = i_last_char;

    // Any byte but a backslash ends a run; the string end clears it too.
    always_comb begin
        n_bs_odd = r_bs_odd;
        if (i_accept) begin
            if (i_last_char) begin
                n_bs_odd = 1'b0;
            end else begin
                n_bs_odd = (i_char_code == CH_BSLASH) ? !r_bs_odd : 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_odd <= 1'b0;
        end else begin
            r_bs_odd <= n_bs_odd;
        end
    end

endmodule

@@ rtl/core/esc_queue.sv @@
// ----------------------------------------------------------------------------
// esc_queue
// Two-entry token queue between the front and back ends.
// ----------------------------------------------------------------------------
module esc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esc_pkg::t_token i_token,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output esc_pkg::t_token o_token
);
    import esc_pkg::*;

    t_token     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_token = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

endmodule

@@ rtl/core/esc_back.sv @@
// ----------------------------------------------------------------------------
// esc_back
// Applies tokens to the quote flag, nesting depths and pending angle, and
// registers one verdict per string.
// ----------------------------------------------------------------------------
module esc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  esc_pkg::t_token i_token,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_verdict
);
    import esc_pkg::*;

    logic       r_in_quote, n_in_quote;
    t_depth     r_paren,  n_paren;
    t_depth     r_square, n_square;
    t_depth     r_list,   n_list;
    t_depth     r_brace,  n_brace;
    logic [1:0] r_pend,   n_pend;
    logic       r_op,     n_op;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [2:0] r_verdict;
    logic [2:0] verdict;
    logic       handled;
    t_cls       cls;

    assign cls = i_token.cls;

    // Non-final tokens never wait; a final one waits for the output slot.
    assign o_pop = i_valid && (!i_token.last || !r_out_valid || i_ready);

    always_comb begin
        n_in_quote = r_in_quote;
        n_paren    = r_paren;
        n_square   = r_square;
        n_list     = r_list;
        n_brace    = r_brace;
        n_pend     = r_pend;
        n_op       = r_op;
        handled    = 1'b0;

        if (!r_op) begin
            if (r_pend == PEND_LT || r_pend == PEND_GT) begin
                n_pend = PEND_NONE;
                if (r_pend == PEND_LT && cls == CLS_LT) begin
                    n_list = sat_inc(r_list);
                    if (n_list == DEPTH_ZERO && r_brace == DEPTH_ZERO) begin
                        n_op = 1'b1;
                    end
                    handled = 1'b1;
                end else if (r_pend == PEND_GT && cls == CLS_GT) begin
                    n_list  = sat_dec(r_list);
                    handled = 1'b1;
                end else if (r_list == DEPTH_ZERO && r_brace == DEPTH_ZERO) begin
                    // lone angle at top level is an operator
                    n_op    = 1'b1;
                    handled = 1'b1;
                end
            end

            if (!handled) begin
                n_pend = PEND_NONE;
                if (cls == CLS_DQUOTE) begin
                    n_in_quote = !r_in_quote;
                end
                if (!n_in_quote) begin
                    if (cls == CLS_LPAREN) begin
                        n_paren = sat_inc(r_paren);
                    end
                    if (cls == CLS_RPAREN) begin
                        n_paren = sat_dec(r_paren);
                    end else if (n_paren == DEPTH_ZERO) begin
                        if (cls == CLS_LSQ) begin
                            n_square = sat_inc(r_square);
                        end
                        if (cls == CLS_RSQ) begin
                            n_square = sat_dec(r_square);
                        end else if (n_square == DEPTH_ZERO) begin
                            if (cls == CLS_LT || cls == CLS_GT) begin
                                if (i_token.last) begin
                                    if (r_list == DEPTH_ZERO && r_brace == DEPTH_ZERO) begin
                                        n_op = 1'b1;
                                    end
                                end else begin
                                    n_pend = (cls == CLS_LT) ? PEND_LT : PEND_GT;
                                end
                            end else if (r_list == DEPTH_ZERO) begin
                                if (cls == CLS_LBRACE) begin
                                    n_brace = sat_inc(r_brace);
                                end
                                if (cls == CLS_RBRACE) begin
                                    n_brace = sat_dec(r_brace);
                                end else if (n_brace == DEPTH_ZERO && cls == CLS_OP) begin
                                    n_op = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        if (n_op) begin
            verdict = V_COMPLEX;
        end else if (n_in_quote) begin
            verdict = V_QUOTE;
        end else if (n_paren != DEPTH_ZERO) begin
            verdict = V_PAREN;
        end else if (n_square != DEPTH_ZERO) begin
            verdict = V_SQUARE;
        end else if (n_list != DEPTH_ZERO) begin
            verdict = V_LIST;
        end else if (n_brace != DEPTH_ZERO) begin
            verdict = V_BRACE;
        end else begin
            verdict = V_SIMPLE;
        end
    end

    // Drain the output slot on a handshake, refill it with a final token.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop && i_token.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote  <= 1'b0;
            r_paren     <= DEPTH_ZERO;
            r_square    <= DEPTH_ZERO;
            r_list      <= DEPTH_ZERO;
            r_brace     <= DEPTH_ZERO;
            r_pend      <= PEND_NONE;
            r_op        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_token.last) begin
                    // start the next string from a clean state
                    r_in_quote  <= 1'b0;
                    r_paren     <= DEPTH_ZERO;
                    r_square    <= DEPTH_ZERO;
                    r_list      <= DEPTH_ZERO;
                    r_brace     <= DEPTH_ZERO;
                    r_pend      <= PEND_NONE;
                    r_op        <= 1'b0;
                end else begin
                    r_in_quote <= n_in_quote;
                    r_paren    <= n_paren;
                    r_square   <= n_square;
                    r_list     <= n_list;
                    r_brace    <= n_brace;
                    r_pend     <= n_pend;
                    r_op       <= n_op;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_token.last) begin
            r_verdict <= verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the expression simplicity checker. Strings are
// streamed one character per transaction through the valid/ready input; a
// scan model in the bench tracks quotes, escapes, bracket depths and angle
// pairing, and every verdict is compared against it in arrival order.
// Directed strings come first, then deep-nesting strings and random
// expressions under several sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_char_code;
    logic       i_last_char;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_verdict;

    expression_simplicity_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_verdict   (o_verdict)
    );

    always #5 i_clk = ~i_clk;

    int sender_idle_pct;
    int receiver_idle_pct;
    int mismatch_count;

    logic [2:0] expected_verdicts[$];
    logic [7:0] expr_buf[$];
    logic [7:0] closer_stack[$];

    // Scan state of the bench model
    logic   ps_in_quote;
    logic   ps_bs_odd;
    t_depth ps_paren;
    t_depth ps_square;
    t_depth ps_list;
    t_depth ps_brace;
    logic [1:0] ps_pend;
    logic   ps_op_seen;

    function automatic void reset_scan_state();
        ps_in_quote = 1'b0;
        ps_bs_odd   = 1'b0;
        ps_paren    = DEPTH_ZERO;
        ps_square   = DEPTH_ZERO;
        ps_list     = DEPTH_ZERO;
        ps_brace    = DEPTH_ZERO;
        ps_pend     = PEND_NONE;
        ps_op_seen  = 1'b0;
    endfunction

    function automatic t_depth bump_depth(input t_depth v, input int delta);
        int hi;
        int lo;
        int r;
        hi = (1 << (DEPTH_WIDTH - 1)) - 1;
        lo = -hi - 1;
        r  = int'(v) + delta;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return t_depth'(r);
    endfunction

    function automatic void judge_lone_angle();
        if (ps_list == DEPTH_ZERO && ps_brace == DEPTH_ZERO) ps_op_seen = 1'b1;
    endfunction

    function automatic void scan_char(input logic [7:0] c, input logic bs_prev,
                                      input logic last);
        logic [1:0] held;
        if (ps_pend == PEND_LT || ps_pend == PEND_GT) begin
            held    = ps_pend;
            ps_pend = PEND_NONE;
            if (held == PEND_LT && c == CH_LT) begin
                ps_list = bump_depth(ps_list, 1);
                // an opener that brings the list count back to zero outside braces is an operator
                if (ps_list == DEPTH_ZERO && ps_brace == DEPTH_ZERO) ps_op_seen = 1'b1;
                return;
            end
            if (held == PEND_GT && c == CH_GT) begin
                ps_list = bump_depth(ps_list, -1);
                return;
            end
            judge_lone_angle();
            if (ps_op_seen) return;
        end
        ps_pend = PEND_NONE;

        if (c == CH_SPACE || c == CH_TAB) return;
        if (c == CH_DQUOTE && !bs_prev) ps_in_quote = !ps_in_quote;
        if (ps_in_quote) return;

        if (c == CH_LPAREN) ps_paren = bump_depth(ps_paren, 1);
        if (c == CH_RPAREN) begin
            ps_paren = bump_depth(ps_paren, -1);
            return;
        end
        if (ps_paren != DEPTH_ZERO) return;

        if (c == CH_LSQ) ps_square = bump_depth(ps_square, 1);
        if (c == CH_RSQ) begin
            ps_square = bump_depth(ps_square, -1);
            return;
        end
        if (ps_square != DEPTH_ZERO) return;

        if (c == CH_LT || c == CH_GT) begin
            if (last) judge_lone_angle();
            else ps_pend = (c == CH_LT) ? PEND_LT : PEND_GT;
            return;
        end
        if (ps_list != DEPTH_ZERO) return;

        if (c == CH_LBRACE) ps_brace = bump_depth(ps_brace, 1);
        if (c == CH_RBRACE) begin
            ps_brace = bump_depth(ps_brace, -1);
            return;
        end
        if (ps_brace != DEPTH_ZERO) return;

        case (c)
            CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_CARET, CH_BANG, CH_GT, CH_LT,
            CH_PCT, CH_PIPE, CH_AMP, CH_EQ, CH_SQUOTE: ps_op_seen = 1'b1;
            default: ;
        endcase
    endfunction

    // Advance the model by one character; returns 1 when a verdict is due.
    function automatic bit predict_verdict(input logic [7:0] c, input logic last,
                                           output logic [2:0] verdict);
        logic bs_prev;
        bs_prev   = ps_bs_odd;
        ps_bs_odd = (c == CH_BSLASH) ? !bs_prev : 1'b0;
        if (!ps_op_seen) scan_char(c, bs_prev, last);
        verdict = V_SIMPLE;
        if (!last) return 1'b0;
        if (ps_op_seen)                   verdict = V_COMPLEX;
        else if (ps_in_quote)             verdict = V_QUOTE;
        else if (ps_paren != DEPTH_ZERO)  verdict = V_PAREN;
        else if (ps_square != DEPTH_ZERO) verdict = V_SQUARE;
        else if (ps_list != DEPTH_ZERO)   verdict = V_LIST;
        else if (ps_brace != DEPTH_ZERO)  verdict = V_BRACE;
        reset_scan_state();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Check verdicts first, then fold in the accepted character.
    always @(posedge i_clk) begin
        logic [2:0] want;
        logic [2:0] next_verdict;
        if (!i_rst_n) begin
            reset_scan_state();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected verdict %0d", o_verdict));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_verdict !== want)
                        report_mismatch($sformatf("verdict expected %0d, actual %0d",
                                                  want, o_verdict));
                end
            end
            if (i_valid && o_ready) begin
                if (predict_verdict(i_char_code, i_last_char, next_verdict))
                    expected_verdicts.push_back(next_verdict);
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Called and returns at a falling edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_expression();
        for (int i = 0; i < expr_buf.size(); i++)
            send_char(expr_buf[i], i == expr_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        expr_buf.delete();
        for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
        send_expression();
    endtask

    // Hold the input until every verdict in flight has arrived.
    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_verdicts.size() != 0);
    endtask

    function automatic logic [7:0] op_char(input int idx);
        case (idx)
            0:  return CH_STAR;
            1:  return CH_SLASH;
            2:  return CH_PLUS;
            3:  return CH_MINUS;
            4:  return CH_CARET;
            5:  return CH_BANG;
            6:  return CH_GT;
            7:  return CH_LT;
            8:  return CH_PCT;
            9:  return CH_PIPE;
            10: return CH_AMP;
            11: return CH_EQ;
            default: return CH_SQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(3))
            0: return 8'h30 + 8'($urandom_range(9));
            1: return 8'h5F;
            default: return 8'h61 + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic void emit_closer(input logic [7:0] closer);
        expr_buf.push_back(closer);
        if (closer == CH_GT) expr_buf.push_back(CH_GT);
    endfunction

    // Build one random expression into expr_buf: mostly well-formed bracket
    // structure with random content, plus operators, quotes, escapes and noise.
    function automatic void gen_expression();
        int n_tokens;
        int r;
        int m;
        expr_buf.delete();
        closer_stack.delete();
        n_tokens = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10);
        repeat (n_tokens) begin
            r = $urandom_range(99);
            if (r < 30) begin
                expr_buf.push_back(plain_char());
            end else if (r < 37) begin
                expr_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            end else if (r < 49) begin
                case ($urandom_range(3))
                    0: begin expr_buf.push_back(CH_LPAREN); closer_stack.push_back(CH_RPAREN); end
                    1: begin expr_buf.push_back(CH_LSQ);    closer_stack.push_back(CH_RSQ);    end
                    2: begin expr_buf.push_back(CH_LBRACE); closer_stack.push_back(CH_RBRACE); end
                    default: begin
                        expr_buf.push_back(CH_LT);
                        expr_buf.push_back(CH_LT);
                        closer_stack.push_back(CH_GT);
                    end
                endcase
            end else if (r < 60) begin
                if (closer_stack.size() != 0 && $urandom_range(9) != 0) begin
                    emit_closer(closer_stack.pop_back());
                end else begin
                    case ($urandom_range(3))
                        0: emit_closer(CH_RPAREN);
                        1: emit_closer(CH_RSQ);
                        2: emit_closer(CH_RBRACE);
                        default: emit_closer(CH_GT);
                    endcase
                end
            end else if (r < 68) begin
                expr_buf.push_back(CH_DQUOTE);
                m = $urandom_range(4);
                repeat (m) begin
                    case ($urandom_range(4))
                        0: expr_buf.push_back(CH_BSLASH);
                        1: begin expr_buf.push_back(CH_BSLASH); expr_buf.push_back(CH_DQUOTE); end
                        2: expr_buf.push_back(op_char($urandom_range(12)));
                        3: expr_buf.push_back(CH_SPACE);
                        default: expr_buf.push_back(plain_char());
                    endcase
                end
                if ($urandom_range(7) != 0) expr_buf.push_back(CH_DQUOTE);
            end else if (r < 74) begin
                // backslash runs of either parity, blanks can break them
                repeat ($urandom_range(1, 3)) expr_buf.push_back(CH_BSLASH);
                if ($urandom_range(2) == 0) expr_buf.push_back(CH_SPACE);
                if ($urandom_range(1)) expr_buf.push_back(CH_DQUOTE);
            end else if (r < 78) begin
                expr_buf.push_back($urandom_range(1) ? CH_LT : CH_GT);
            end else if (r < 82) begin
                expr_buf.push_back(op_char($urandom_range(12)));
            end else begin
                expr_buf.push_back(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(4) != 0) begin
            while (closer_stack.size() != 0) emit_closer(closer_stack.pop_back());
        end
        if (expr_buf.size() == 0) expr_buf.push_back(plain_char());
    endfunction

    task automatic test_field_extremes();
        expr_buf = '{8'h00, 8'hFF};
        send_expression();
    endtask

    task automatic test_operators();
        for (int k = 0; k < 13; k++) begin
            expr_buf = '{op_char(k)};
            send_expression();
        end
    endtask

    task automatic test_special_cases();
        send_text("\\\"");  // escaped quote does not open a string
        send_text(">><<");  // list opener closing a list
        send_text("{<}");   // lone angle inside braces
    endtask

    task automatic test_depth_saturation();
        logic [7:0] opener;
        logic [7:0] closer;
        int         count;
        for (int pass = 0; pass < 2; pass++) begin
            case ($urandom_range(2))
                0: begin opener = CH_LPAREN; closer = CH_RPAREN; end
                1: begin opener = CH_LSQ;    closer = CH_RSQ;    end
                default: begin opener = CH_LBRACE; closer = CH_RBRACE; end
            endcase
            count = $urandom_range(129, 131);
            expr_buf.delete();
            repeat (count) expr_buf.push_back(pass == 0 ? opener : closer);
            expr_buf.push_back(8'h78);
            send_expression();
        end
    endtask

    task automatic test_random_expressions(input int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars) begin
            gen_expression();
            send_expression();
            sent += expr_buf.size();
        end
    endtask

    initial begin
        int guard;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_char_code       = 8'h00;
        i_last_char       = 1'b0;
        i_ready           = 1'b0;
        mismatch_count    = 0;
        sender_idle_pct   = 37;
        receiver_idle_pct = 71;
        reset_scan_state();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_field_extremes();
        test_operators();
        test_special_cases();
        wait_for_verdicts();
        test_depth_saturation();
        test_random_expressions(200);
        wait_for_verdicts();

        sender_idle_pct   = 71;
        receiver_idle_pct = 37;
        test_random_expressions(200);
        wait_for_verdicts();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_expressions(200);

        i_valid <= 1'b0;
        guard = 0;
        do begin
            @(negedge i_clk);
            guard++;
        end while (expected_verdicts.size() != 0 && guard < 1000);
        repeat (8) @(negedge i_clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));

        if (mismatch_count == 0) begin
            $display("expression_simplicity_checker regression: pass");
        end else begin
            $display("expression_simplicity_checker regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("expression_simplicity_checker regression: fail");
        $finish;
    end

endmodule
